[src/rv64ie_pkg.sv]
package rv64ie_pkg;

    typedef enum logic [4:0] {
        OP_LUI   = 5'd0,
        OP_AUIPC = 5'd1,
        OP_JAL   = 5'd2,
        OP_JALR  = 5'd3,
        OP_BEQ   = 5'd4,
        OP_BNE   = 5'd5,
        OP_BLTU  = 5'd6,
        OP_BGEU  = 5'd7,
        OP_LW    = 5'd8,
        OP_LBU   = 5'd9,
        OP_LHU   = 5'd10,
        OP_SW    = 5'd11,
        OP_ADDI  = 5'd12,
        OP_XORI  = 5'd13,
        OP_ANDI  = 5'd14,
        OP_SLLI  = 5'd15,
        OP_SRLI  = 5'd16,
        OP_ADD   = 5'd17,
        OP_SUB   = 5'd18,
        OP_LD    = 5'd19,
        OP_SD    = 5'd20,
        OP_ADDIW = 5'd21,
        OP_SLLIW = 5'd22,
        OP_ADDW  = 5'd23,
        OP_MUL   = 5'd24,
        OP_DIVU  = 5'd25
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_MUL,
        S_MEM_RD,
        S_MEM_WAIT,
        S_MEM_WR,
        S_DONE
    } state_t;

    localparam int XLEN     = 64;
    localparam int STEP_CNT = 64;

    function automatic logic [2:0] last_byte(input op_t op);
        logic [2:0] r;
        r = 3'd0;
        unique case (op)
            OP_LW, OP_SW: r = 3'd3;
            OP_LHU:       r = 3'd1;
            OP_LD, OP_SD: r = 3'd7;
            default:      r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

[src/rv64_instruction_execute_core.sv]
// Each request passes S_EXEC and then S_DONE; mul and divu iterate in S_MUL or S_DIV
// (one bit per cycle), stores write one byte per S_MEM_WR step, and loads read each byte
// through S_MEM_RD and S_MEM_WAIT. One request at a time: s_tready returns as the result
// register loads; a stalled result holds the core.
// Reset (aresetn low, synchronous) clears the PC and control; data memory is not cleared.
// MEM_BYTES must be a power of two; byte addresses wrap by masking.
module rv64_instruction_execute_core #(
    parameter int MEM_BYTES = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [175:0] s_tdata,  // mode, src_a, src_b, immediate, dest_index
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata   // dest_write, dest_number, dest_value, next_pc
);
    import rv64ie_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [XLEN-1:0] a_reg, a_next, b_reg, b_next, imm_reg, imm_next;
    logic [4:0]      rd_reg, rd_next;
    logic [XLEN-1:0] pc_reg, pc_next, npc_reg, npc_next, val_reg, val_next;
    logic            wr_reg, wr_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [XLEN-1:0] rem_reg, rem_next, quo_reg, quo_next, dvs_reg, dvs_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic            mv_reg, mv_next;
    logic [135:0]    mdata_reg, mdata_next;

    logic            ram_we;
    logic [7:0]      ram_wdata, ram_rdata;

    logic [XLEN:0]   div_tmp, div_sub;
    logic            div_ge;
    logic [XLEN-1:0] div_rem, div_quo, addr, sum_pc_imm;
    logic [AW-1:0]   ptr_inc;
    logic            is_last;

    rv64ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = mdata_reg;
    assign ram_we    = (state_reg == S_MEM_WR);
    assign ram_wdata = b_reg[7:0];

    assign div_tmp    = {rem_reg, quo_reg[XLEN-1]};
    assign div_sub    = div_tmp - {1'b0, dvs_reg};
    assign div_ge     = div_tmp >= {1'b0, dvs_reg};
    assign div_rem    = div_ge ? div_sub[XLEN-1:0] : div_tmp[XLEN-1:0];
    assign div_quo    = {quo_reg[XLEN-2:0], div_ge};
    assign addr       = a_reg + imm_reg;
    assign sum_pc_imm = pc_reg + imm_reg;
    assign ptr_inc    = (ptr_reg == AW'(MEM_BYTES - 1)) ? '0 : ptr_reg + 1'b1;
    assign is_last    = (cnt_reg[2:0] == last_byte(op_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            mv_reg    <= mv_next;
        end
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        imm_reg   <= imm_next;
        rd_reg    <= rd_next;
        npc_reg   <= npc_next;
        val_reg   <= val_next;
        wr_reg    <= wr_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        ptr_reg   <= ptr_next;
        mdata_reg <= mdata_next;
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        imm_next   = imm_reg;
        rd_next    = rd_reg;
        pc_next    = pc_reg;
        npc_next   = npc_reg;
        val_next   = val_reg;
        wr_next    = wr_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        ptr_next   = ptr_reg;
        mv_next    = mv_reg;
        mdata_next = mdata_reg;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_t'(s_tdata[4:0]);
                    a_next     = s_tdata[68:5];
                    b_next     = s_tdata[132:69];
                    imm_next   = {{32{s_tdata[164]}}, s_tdata[164:133]};
                    rd_next    = s_tdata[169:165];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                npc_next   = pc_reg + 64'd4;
                val_next   = '0;
                wr_next    = 1'b1;
                cnt_next   = '0;
                state_next = S_DONE;
                unique case (op_reg)
                    OP_LUI:   val_next = {imm_reg[51:0], 12'd0};
                    OP_AUIPC: val_next = pc_reg + {imm_reg[51:0], 12'd0};
                    OP_JAL: begin
                        val_next = pc_reg + 64'd4;
                        npc_next = sum_pc_imm;
                    end
                    OP_JALR: begin
                        val_next = pc_reg + 64'd4;
                        npc_next = {addr[XLEN-1:1], 1'b0};
                    end
                    OP_BEQ: begin
                        wr_next = 1'b0;
                        if (a_reg == b_reg) npc_next = sum_pc_imm;
                    end
                    OP_BNE: begin
                        wr_next = 1'b0;
                        if (a_reg != b_reg) npc_next = sum_pc_imm;
                    end
                    OP_BLTU: begin
                        wr_next = 1'b0;
                        if (a_reg < b_reg) npc_next = sum_pc_imm;
                    end
                    OP_BGEU: begin
                        wr_next = 1'b0;
                        if (a_reg >= b_reg) npc_next = sum_pc_imm;
                    end
                    OP_LW, OP_LBU, OP_LHU, OP_LD: begin
                        ptr_next   = addr[AW-1:0];
                        state_next = S_MEM_RD;
                    end
                    OP_SW, OP_SD: begin
                        wr_next    = 1'b0;
                        ptr_next   = addr[AW-1:0];
                        state_next = S_MEM_WR;
                    end
                    OP_ADDI:  val_next = addr;
                    OP_XORI:  val_next = a_reg ^ imm_reg;
                    OP_ANDI:  val_next = a_reg & imm_reg;
                    OP_SLLI:  val_next = a_reg << imm_reg[5:0];
                    OP_SRLI:  val_next = a_reg >> imm_reg[5:0];
                    OP_ADD:   val_next = a_reg + b_reg;
                    OP_SUB:   val_next = a_reg - b_reg;
                    OP_ADDIW: val_next = {{32{addr[31]}}, addr[31:0]};
                    OP_SLLIW: begin
                        val_next = a_reg << imm_reg[4:0];
                        val_next = {{32{val_next[31]}}, val_next[31:0]};
                    end
                    OP_ADDW: begin
                        val_next = a_reg + b_reg;
                        val_next = {{32{val_next[31]}}, val_next[31:0]};
                    end
                    OP_MUL:   state_next = S_MUL;
                    OP_DIVU: begin
                        rem_next   = '0;
                        quo_next   = a_reg;
                        dvs_next   = b_reg;
                        state_next = S_DIV;
                    end
                    default:  wr_next = 1'b0;
                endcase
            end
            S_DIV: begin
                rem_next = div_rem;
                quo_next = div_quo;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(STEP_CNT - 1)) begin
                    cnt_next   = '0;
                    val_next   = div_quo;
                    state_next = S_DONE;
                end
            end
            S_MUL: begin
                if (b_reg[0]) val_next = val_reg + a_reg;
                a_next   = {a_reg[XLEN-2:0], 1'b0};
                b_next   = {1'b0, b_reg[XLEN-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(STEP_CNT - 1)) state_next = S_DONE;
            end
            S_MEM_RD: begin
                state_next = S_MEM_WAIT;
            end
            S_MEM_WAIT: begin
                val_next[{cnt_reg[2:0], 3'b000} +: 8] = ram_rdata;
                ptr_next = ptr_inc;
                cnt_next = cnt_reg + 1'b1;
                if (is_last) begin
                    if (op_reg == OP_LW) val_next[63:32] = {32{val_next[31]}};
                    state_next = S_DONE;
                end else begin
                    state_next = S_MEM_RD;
                end
            end
            S_MEM_WR: begin
                b_next   = {8'd0, b_reg[XLEN-1:8]};
                ptr_next = ptr_inc;
                cnt_next = cnt_reg + 1'b1;
                if (is_last) state_next = S_DONE;
            end
            S_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = {2'b00, npc_reg, (wr_reg ? val_reg : 64'd0), rd_reg, wr_reg};
                    pc_next    = npc_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_mem_pow2: assert property (@(posedge aclk)
        (MEM_BYTES & (MEM_BYTES - 1)) == 0) else $error("memory size not a power of two");
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !ram_we) else $error("memory write while idle");
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("second request taken");
    a_nowrite_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[69:6] == 64'd0))
        else $error("value without write flag");
    a_pc_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && state_next == S_IDLE) |=> (pc_reg == m_tdata[133:70]))
        else $error("pc differs from reported next pc");
`endif
endmodule

[src/rv64ie_ram.sv]
module rv64ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import rv64ie_pkg::*;

    localparam int MEM_SIZE    = 4096;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [4:0]  mode;
        logic [63:0] src_a;
        logic [63:0] src_b;
        logic [31:0] imm;
        logic [4:0]  rd;
    } instr_t;

    typedef struct packed {
        logic [63:0] next_pc;
        logic [63:0] value;
        logic [4:0]  rd;
        logic        wr;
    } retire_t;

    typedef struct {
        logic [11:0] addr;
        int          nbytes;
    } store_rec_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;

    rv64_instruction_execute_core #(.MEM_BYTES(MEM_SIZE)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    logic [63:0]  model_pc;
    logic [7:0]   model_mem [MEM_SIZE];
    retire_t      retire_q[$];
    store_rec_t   stores[$];
    int           errors;
    int           sent;
    int           retired;
    int           cycles;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_left;
    bit           long_hold_req;
    bit           hold_started;
    bit [31:0]    ops_seen;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] mem_load(input logic [63:0] addr, input int nbytes);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < nbytes; k++) begin
            v[8*k +: 8] = model_mem[(addr + k) % MEM_SIZE];
        end
        return v;
    endfunction

    task automatic mem_store(input logic [63:0] addr, input logic [63:0] v, input int nbytes);
        for (int k = 0; k < nbytes; k++) begin
            model_mem[(addr + k) % MEM_SIZE] = v[8*k +: 8];
        end
    endtask

    task automatic execute_model(input instr_t in);
        logic [63:0] imm;
        logic [63:0] addr;
        logic [63:0] nxt;
        logic [63:0] val;
        logic        wr;
        retire_t     r;
        imm  = sext32(in.imm);
        addr = in.src_a + imm;
        nxt  = model_pc + 64'd4;
        val  = '0;
        wr   = 1'b1;
        case (in.mode)
            OP_LUI:   val = imm << 12;
            OP_AUIPC: val = model_pc + (imm << 12);
            OP_JAL: begin
                val = model_pc + 64'd4;
                nxt = model_pc + imm;
            end
            OP_JALR: begin
                val = model_pc + 64'd4;
                nxt = {addr[63:1], 1'b0};
            end
            OP_BEQ: begin
                wr = 1'b0;
                if (in.src_a == in.src_b) nxt = model_pc + imm;
            end
            OP_BNE: begin
                wr = 1'b0;
                if (in.src_a != in.src_b) nxt = model_pc + imm;
            end
            OP_BLTU: begin
                wr = 1'b0;
                if (in.src_a < in.src_b) nxt = model_pc + imm;
            end
            OP_BGEU: begin
                wr = 1'b0;
                if (in.src_a >= in.src_b) nxt = model_pc + imm;
            end
            OP_LW:    val = sext32(32'(mem_load(addr, 4)));
            OP_LBU:   val = mem_load(addr, 1);
            OP_LHU:   val = mem_load(addr, 2);
            OP_SW: begin
                wr = 1'b0;
                mem_store(addr, in.src_b, 4);
            end
            OP_ADDI:  val = in.src_a + imm;
            OP_XORI:  val = in.src_a ^ imm;
            OP_ANDI:  val = in.src_a & imm;
            OP_SLLI:  val = in.src_a << imm[5:0];
            OP_SRLI:  val = in.src_a >> imm[5:0];
            OP_ADD:   val = in.src_a + in.src_b;
            OP_SUB:   val = in.src_a - in.src_b;
            OP_LD:    val = mem_load(addr, 8);
            OP_SD: begin
                wr = 1'b0;
                mem_store(addr, in.src_b, 8);
            end
            OP_ADDIW: val = sext32(in.src_a[31:0] + imm[31:0]);
            OP_SLLIW: val = sext32(in.src_a[31:0] << imm[4:0]);
            OP_ADDW:  val = sext32(in.src_a[31:0] + in.src_b[31:0]);
            OP_MUL:   val = in.src_a * in.src_b;
            OP_DIVU:  val = (in.src_b == 0) ? '1 : in.src_a / in.src_b;
            default:  wr = 1'b0;
        endcase
        model_pc   = nxt;
        r.wr       = wr;
        r.rd       = in.rd;
        r.value    = wr ? val : '0;
        r.next_pc  = nxt;
        retire_q.push_back(r);
    endtask

    task automatic send_instr(input instr_t in);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, in.rd, in.imm, in.src_b, in.src_a, in.mode};
        do @(posedge aclk); while (!s_tready);
        execute_model(in);
        if (in.mode == OP_SW)
            stores.push_back('{addr: 12'(in.src_a + sext32(in.imm)), nbytes: 4});
        if (in.mode == OP_SD)
            stores.push_back('{addr: 12'(in.src_a + sext32(in.imm)), nbytes: 8});
        ops_seen[in.mode] = 1'b1;
        sent++;
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: mismatch on %s at result %0d: got %h expected %h",
                 field, retired, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        retire_t got;
        retire_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[133:0];
            if (retire_q.size() == 0) begin
                report_mismatch("unexpected result", got.value, '0);
            end else begin
                want = retire_q.pop_front();
                if (got.wr !== want.wr) report_mismatch("dest_write", got.wr, want.wr);
                if (got.rd !== want.rd) report_mismatch("dest_number", got.rd, want.rd);
                if (got.value !== want.value) report_mismatch("dest_value", got.value, want.value);
                if (got.next_pc !== want.next_pc)
                    report_mismatch("next_pc", got.next_pc, want.next_pc);
            end
            retired++;
        end
    end

    always @(posedge aclk) begin
        if (long_hold_req && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic instr_t mem_instr(input logic [4:0] op, input logic [11:0] addr);
        instr_t in;
        in.mode  = op;
        in.imm   = $urandom;
        in.src_a = {$urandom, $urandom};
        in.src_a[11:0] = addr - in.imm[11:0];
        in.src_b = {$urandom, $urandom};
        in.rd    = 5'($urandom);
        return in;
    endfunction

    function automatic instr_t alu_instr(input logic [4:0] op, input logic [63:0] a,
                                         input logic [63:0] b, input logic [31:0] imm);
        instr_t in;
        in.mode  = op;
        in.src_a = a;
        in.src_b = b;
        in.imm   = imm;
        in.rd    = 5'($urandom);
        return in;
    endfunction

    function automatic instr_t random_load();
        store_rec_t rec;
        int         w;
        logic [4:0] op;
        rec = stores[$urandom_range(stores.size() - 1)];
        do w = 1 << $urandom_range(3); while (w > rec.nbytes);
        case (w)
            1:       op = OP_LBU;
            2:       op = OP_LHU;
            4:       op = OP_LW;
            default: op = OP_LD;
        endcase
        return mem_instr(op, 12'(rec.addr + $urandom_range(rec.nbytes - w)));
    endfunction

    function automatic instr_t random_instr();
        instr_t in;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            in = mem_instr($urandom_range(1) ? OP_SD : OP_SW, 12'($urandom));
        end else if (pick < 26 && stores.size() > 0) begin
            in = random_load();
        end else begin
            in = alu_instr(5'($urandom_range(31)), {$urandom, $urandom}, {$urandom, $urandom},
                           $urandom);
            if (in.mode == OP_LW || in.mode == OP_LBU || in.mode == OP_LHU || in.mode == OP_LD
                || in.mode == OP_SW || in.mode == OP_SD) in.mode = OP_ADD;
            if ($urandom_range(3) == 0) in.src_b = in.src_a;
            if (in.mode == OP_DIVU && $urandom_range(3) == 0) in.src_b = $urandom_range(3);
        end
        return in;
    endfunction

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_instr(alu_instr(OP_LUI, '0, '0, 32'h8000_0000));
        send_instr(alu_instr(OP_AUIPC, '0, '0, 32'h7fff_ffff));
        send_instr(alu_instr(OP_JAL, '0, '0, 32'hffff_fff8));
        send_instr(alu_instr(OP_JALR, 64'h1001, '0, 32'h0000_0002));
        send_instr(alu_instr(OP_BEQ, 64'd5, 64'd5, 32'd16));
        send_instr(alu_instr(OP_BNE, 64'd5, 64'd5, 32'd16));
        send_instr(alu_instr(OP_BLTU, '0, '1, 32'hffff_fff0));
        send_instr(alu_instr(OP_BGEU, '0, '1, 32'd8));
        send_instr(mem_instr(OP_SD, 12'hffe));
        send_instr(mem_instr(OP_LD, 12'hffe));
        send_instr(mem_instr(OP_SW, 12'h000));
        send_instr(mem_instr(OP_LW, 12'h000));
        send_instr(mem_instr(OP_LBU, 12'hfff));
        send_instr(mem_instr(OP_LHU, 12'h001));
        send_instr(alu_instr(OP_ADDI, '1, '0, 32'd1));
        send_instr(alu_instr(OP_XORI, 64'h1234, '0, 32'hffff_ffff));
        send_instr(alu_instr(OP_ANDI, '1, '0, 32'h8000_0000));
        send_instr(alu_instr(OP_SLLI, 64'h1, '0, 32'd127));
        send_instr(alu_instr(OP_SRLI, '1, '0, 32'd65));
        send_instr(alu_instr(OP_ADD, '1, '1, '0));
        send_instr(alu_instr(OP_SUB, '0, 64'd1, '0));
        send_instr(alu_instr(OP_ADDIW, 64'h7fff_ffff, '0, 32'd1));
        send_instr(alu_instr(OP_SLLIW, 64'h1, '0, 32'd63));
        send_instr(alu_instr(OP_ADDW, '1, 64'h1, '0));
        send_instr(alu_instr(OP_MUL, '1, '1, '0));
        send_instr(alu_instr(OP_DIVU, '1, '0, '0));
        send_instr(alu_instr(OP_DIVU, '1, 64'd3, '0));
        send_instr(alu_instr(5'd31, '1, '1, '1));
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_instr(random_instr());
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  = 1'b1;
        repeat (20) send_instr(random_instr());
    endtask

    initial begin
        sent           = 0;
        long_hold_req  = 1'b0;
        ops_seen       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        model_pc       = '0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(380, 0, 0);
        test_random(380, 56, 0);
        test_random(380, 0, 56);
        test_random(380, 29, 29);
        test_backpressure();
        s_tvalid <= 1'b0;
        while (retire_q.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("tb: %0d instructions sent, %0d results checked, %0d opcode values used",
                 sent, retired, $countones(ops_seen));
        $display("tb: covered all ops, wrapped memory, idle/stall phases and long hold-off");
        if (errors == 0 && retire_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
